// ----- rtl/core/paimd_pkg.sv -----
// ----------------------------------------------------------------------------
// paimd_pkg
// Shared types and constants of the per-peer AIMD token bucket block.
// ----------------------------------------------------------------------------
package paimd_pkg;

  localparam int unsigned RATE_W = 16;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned FAD_W  = 33;

  localparam logic [RATE_W-1:0] TOKEN_ONE = 16'd256;
  localparam logic [FAD_W-1:0]  NONE_MARK = {FAD_W{1'b1}};

  localparam logic [2:0] REG_MIN_RATE  = 3'd0;
  localparam logic [2:0] REG_MAX_RATE  = 3'd1;
  localparam logic [2:0] REG_DEC_FACT  = 3'd2;
  localparam logic [2:0] REG_INC_STEP  = 3'd3;
  localparam logic [2:0] REG_INIT_RATE = 3'd4;
  localparam logic [2:0] REG_LEADER    = 3'd5;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INC  = 2'd1;
  localparam logic [1:0] KIND_DEC  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch input item and read the table entry
    logic div_start; // start the increase divider
    logic div_step;  // one radix-2 step of the divider
    logic commit;    // write back the entry and load the result register
  } paimd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div; // the item is an additive increase with a nonzero rate
  } paimd_sts_t;

endpackage

// ----- rtl/core/paimd_ctrl.sv -----
// ----------------------------------------------------------------------------
// paimd_ctrl
// Sequencer: capture, read, optional 32-step division, commit, output hold.
// ----------------------------------------------------------------------------
module paimd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  paimd_pkg::paimd_sts_t sts,
  output paimd_pkg::paimd_cmd_t cmd
);
  import paimd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_DONE} state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;

  // A new item may enter only when no result waits or the waiting result is
  // taken in the same cycle.
  assign in_ready  = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          cnt_nxt       = 5'd31;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.commit = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ----- rtl/core/paimd_dp.sv -----
// ----------------------------------------------------------------------------
// paimd_dp
// Peer table, configuration registers, serial divider and result register.
// ----------------------------------------------------------------------------
module paimd_dp #(
  parameter int unsigned PEERS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  in_mode,
  input  logic [3:0]            in_peer,
  input  logic [31:0]           in_message_id,
  input  logic [31:0]           in_ack_sequence,
  output logic                  out_forwarded,
  output logic [31:0]           out_assigned_sequence,
  output logic [1:0]            out_update_kind,
  output logic [15:0]           out_peer_rate,
  input  paimd_pkg::paimd_cmd_t cmd,
  output paimd_pkg::paimd_sts_t sts
);
  import paimd_pkg::*;

  localparam int unsigned IDX_W = (PEERS > 1) ? $clog2(PEERS) : 1;

  // Configuration registers.
  logic [15:0] min_rate_r, max_rate_r, inc_step_r, init_rate_r;
  logic [7:0]  dec_fact_r;
  logic [3:0]  leader_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rate_r  <= 16'd64;
      max_rate_r  <= 16'd1024;
      dec_fact_r  <= 8'd128;
      inc_step_r  <= 16'd64;
      init_rate_r <= 16'd256;
      leader_r    <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_RATE:  min_rate_r  <= cfg_data;
        REG_MAX_RATE:  max_rate_r  <= cfg_data;
        REG_DEC_FACT:  dec_fact_r  <= cfg_data[7:0];
        REG_INC_STEP:  inc_step_r  <= cfg_data;
        REG_INIT_RATE: init_rate_r <= cfg_data;
        REG_LEADER:    leader_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Per-peer table; touched bits reset, the rest is loaded on first use.
  logic [PEERS-1:0] touched_r;
  logic [15:0] rate_m   [PEERS];
  logic [15:0] bucket_m [PEERS];
  logic [31:0] nseq_m   [PEERS];
  logic [31:0] lack_m   [PEERS];
  logic        acked_m  [PEERS];
  logic        mayd_m   [PEERS];
  logic [32:0] fad_m    [PEERS];

  // Captured item and entry.
  logic        mode_r, valid_peer_r, leader_r2, touched_q;
  logic [IDX_W-1:0] idx_r;
  logic [31:0] mid_r, aseq_r;
  logic [15:0] rate_q, bucket_q;
  logic [31:0] nseq_q, lack_q;
  logic        acked_q, mayd_q;
  logic [32:0] fad_q;

  logic in_range;
  logic [IDX_W-1:0] peer_idx;
  assign in_range = ({28'd0, in_peer} < 32'(PEERS));
  assign peer_idx = IDX_W'(in_peer);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r       <= in_mode;
      idx_r        <= peer_idx;
      mid_r        <= in_message_id;
      aseq_r       <= in_ack_sequence;
      valid_peer_r <= in_range;
      leader_r2    <= (in_peer == leader_r);
      touched_q    <= touched_r[peer_idx];
      rate_q       <= rate_m[peer_idx];
      bucket_q     <= bucket_m[peer_idx];
      nseq_q       <= nseq_m[peer_idx];
      lack_q       <= lack_m[peer_idx];
      acked_q      <= acked_m[peer_idx];
      mayd_q       <= mayd_m[peer_idx];
      fad_q        <= fad_m[peer_idx];
    end
  end

  // Effective entry after a first-use load.
  logic [15:0] e_rate, e_bucket;
  logic [31:0] e_nseq, e_lack;
  logic        e_acked, e_mayd;
  logic [32:0] e_fad;
  always_comb begin
    if (touched_q) begin
      e_rate = rate_q; e_bucket = bucket_q; e_nseq = nseq_q; e_lack = lack_q;
      e_acked = acked_q; e_mayd = mayd_q; e_fad = fad_q;
    end else begin
      e_rate = init_rate_r; e_bucket = init_rate_r; e_nseq = '0; e_lack = '0;
      e_acked = 1'b0; e_mayd = 1'b1; e_fad = NONE_MARK;
    end
  end

  logic gap, arm, is_inc;
  assign gap    = {1'b0, aseq_r} > ({1'b0, e_lack} + 33'd1);
  assign arm    = (e_fad == NONE_MARK) || ({1'b0, mid_r} > e_fad);
  assign is_inc = mode_r && valid_peer_r && e_acked && !gap;
  assign sts.need_div = is_inc && (e_rate != 16'd0);

  // Restoring divider: increase_step*min_rate (32 bits) over rate.
  logic [31:0] quo_r;
  logic [16:0] rem_r;
  logic [16:0] rem_sh;
  logic [17:0] rem_try;
  assign rem_sh  = {rem_r[15:0], quo_r[31]};
  assign rem_try = {1'b0, rem_sh} - {2'b00, e_rate};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r <= {16'd0, inc_step_r} * {16'd0, min_rate_r};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!rem_try[17]) begin
        rem_r <= rem_try[16:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  // Decrease product.
  logic [23:0] dprod;
  logic [15:0] dec_rate;
  assign dprod    = {8'd0, e_rate} * {16'd0, dec_fact_r};
  assign dec_rate = (dprod[23:8] < min_rate_r) ? min_rate_r : dprod[23:8];

  logic [32:0] inc_sum;
  logic [15:0] inc_rate;
  assign inc_sum  = (e_rate == 16'd0) ? 33'd65535 : ({17'd0, e_rate} + {1'b0, quo_r});
  assign inc_rate = (inc_sum > {17'd0, max_rate_r}) ? max_rate_r : inc_sum[15:0];

  // Send path.
  logic        has_tok;
  logic [15:0] b_left;
  logic [16:0] b_sum;
  assign has_tok = (e_bucket >= TOKEN_ONE);
  assign b_left  = has_tok ? (e_bucket - TOKEN_ONE) : e_bucket;
  assign b_sum   = {1'b0, b_left} + {1'b0, e_rate};

  logic        do_write;
  logic        w_fwd;
  logic [1:0]  w_kind;
  logic [15:0] w_rate, w_bucket;
  logic [31:0] w_nseq, w_lack, w_seq;
  logic        w_acked, w_mayd;
  logic [32:0] w_fad;
  logic        m2;

  always_comb begin
    do_write = 1'b0; w_fwd = 1'b0; w_kind = KIND_NONE; w_seq = '0;
    w_rate = e_rate; w_bucket = e_bucket; w_nseq = e_nseq; w_lack = e_lack;
    w_acked = e_acked; w_mayd = e_mayd; w_fad = e_fad; m2 = e_mayd;
    if (valid_peer_r) begin
      if (!mode_r) begin
        if (!leader_r2) begin
          do_write = 1'b1;
          if (has_tok) begin
            w_fwd  = 1'b1;
            w_seq  = e_nseq;
            w_nseq = e_nseq + 32'd1;
            if (e_fad == NONE_MARK) w_fad = {1'b0, mid_r};
          end
          w_bucket = b_sum[16] ? 16'hFFFF : b_sum[15:0];
        end
      end else begin
        do_write = 1'b1;
        if (e_acked) begin
          if (arm) m2 = 1'b1;
          w_mayd = m2;
          if (gap) begin
            if (m2) begin
              w_rate = dec_rate; w_mayd = 1'b0; w_fad = NONE_MARK;
              w_kind = KIND_DEC;
            end
          end else begin
            w_rate = inc_rate; w_kind = KIND_INC;
          end
        end
        w_lack  = aseq_r;
        w_acked = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_write) begin
      rate_m[idx_r]   <= w_rate;
      bucket_m[idx_r] <= w_bucket;
      nseq_m[idx_r]   <= w_nseq;
      lack_m[idx_r]   <= w_lack;
      acked_m[idx_r]  <= w_acked;
      mayd_m[idx_r]   <= w_mayd;
      fad_m[idx_r]    <= w_fad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touched_r <= '0;
    end else if (cmd.commit && do_write) begin
      touched_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_forwarded         <= w_fwd;
      out_assigned_sequence <= w_seq;
      out_update_kind       <= w_kind;
      out_peer_rate         <= valid_peer_r ? w_rate : 16'd0;
    end
  end

endmodule

// ----- rtl/core/per_peer_aimd_token_bucket.sv -----
// ----------------------------------------------------------------------------
// per_peer_aimd_token_bucket
// Per-peer AIMD rate control with Q8.8 token buckets.
// ----------------------------------------------------------------------------
// Usage: an item on the in_ channel is either a send attempt (mode 0) or an
// acknowledgement (mode 1) for one peer. Each accepted transaction produces
// exactly one transaction on the out_ channel, in order. Both channels use
// valid/ready handshakes.
// Processing: a send or an acknowledgement that is no additive increase
// passes through capture, evaluation and commit to out_valid; an additive
// increase with a nonzero rate also divides the increase step times min_rate
// by the rate with a restoring divider that retires one quotient bit per cycle.
// One item is in flight at a time; no new item is accepted before it commits.
// Reset clears the configuration to its defaults and marks every peer entry
// untouched; an untouched entry is loaded from initial_rate on first use.
// When the receiver stalls, the result stays in the output register and no
// next item is accepted until the old result is being taken.
// Configuration is written through cfg_we/cfg_index/cfg_data when idle; the
// user must keep to this, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module per_peer_aimd_token_bucket #(
  parameter int unsigned PEERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [3:0]  in_peer,
  input  logic [31:0] in_message_id,
  input  logic [31:0] in_ack_sequence,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_forwarded,
  output logic [31:0] out_assigned_sequence,
  output logic [1:0]  out_update_kind,
  output logic [15:0] out_peer_rate
);
  import paimd_pkg::*;

  paimd_cmd_t cmd;
  paimd_sts_t sts;

  paimd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  paimd_dp #(.PEERS(PEERS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_mode              (in_mode),
    .in_peer              (in_peer),
    .in_message_id        (in_message_id),
    .in_ack_sequence      (in_ack_sequence),
    .out_forwarded        (out_forwarded),
    .out_assigned_sequence(out_assigned_sequence),
    .out_update_kind      (out_update_kind),
    .out_peer_rate        (out_peer_rate),
    .cmd                  (cmd),
    .sts                  (sts)
  );

endmodule

// ----- rtl/core/paimd_checker.sv -----
// ----------------------------------------------------------------------------
// paimd_checker
// Port-level checks of the per-peer AIMD token bucket.
// ----------------------------------------------------------------------------
module paimd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_forwarded,
  input logic [31:0] out_assigned_sequence,
  input logic [1:0]  out_update_kind
);
  import paimd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_update_kind != 2'd3) else $error("bad update kind");

  a_send_no_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_forwarded |-> out_update_kind == KIND_NONE)
    else $error("forwarded with update");

  a_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_forwarded |-> out_assigned_sequence == 32'd0)
    else $error("sequence without forward");

  a_no_result_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("overlapping accept");

endmodule

bind per_peer_aimd_token_bucket paimd_checker u_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_forwarded        (out_forwarded),
  .out_assigned_sequence(out_assigned_sequence),
  .out_update_kind      (out_update_kind)
);

// ----- sim/tb_per_peer_aimd_token_bucket.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_peer_aimd_token_bucket
// Self-checking bench for the per-peer AIMD token bucket block. It drives
// send attempts and acknowledgements with random idling on both sides and
// compares every result, field by field, with an in-bench rate predictor.
// ----------------------------------------------------------------------------
module tb_per_peer_aimd_token_bucket;
  import paimd_pkg::*;

  localparam int NPEERS = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [3:0]  in_peer;
  logic [31:0] in_message_id;
  logic [31:0] in_ack_sequence;
  logic        out_valid;
  logic        out_ready;
  logic        out_forwarded;
  logic [31:0] out_assigned_sequence;
  logic [1:0]  out_update_kind;
  logic [15:0] out_peer_rate;

  per_peer_aimd_token_bucket #(.PEERS(NPEERS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_peer(in_peer), .in_message_id(in_message_id),
    .in_ack_sequence(in_ack_sequence),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_forwarded(out_forwarded),
    .out_assigned_sequence(out_assigned_sequence),
    .out_update_kind(out_update_kind), .out_peer_rate(out_peer_rate)
  );

  typedef struct packed {
    logic        forwarded;
    logic [31:0] seq;
    logic [1:0]  kind;
    logic [15:0] rate;
  } rate_result_t;

  // Predictor copy of the configuration and the per-peer table.
  logic [15:0] p_min_rate, p_max_rate, p_inc_step, p_init_rate;
  logic [7:0]  p_dec_factor;
  logic [3:0]  p_leader;
  logic        pt_touched [NPEERS];
  logic [15:0] pt_rate [NPEERS];
  logic [15:0] pt_bucket [NPEERS];
  logic [31:0] pt_next_seq [NPEERS];
  logic [31:0] pt_last_ack [NPEERS];
  logic        pt_acked [NPEERS];
  logic        pt_may_dec [NPEERS];
  logic [32:0] pt_first_after [NPEERS];

  rate_result_t expected_results[$];
  int  mismatch_count;
  int  idle_cycles;
  bit  timed_out;
  bit  receiver_hold;     // forces a long receiver stall when set
  logic [31:0] msg_counter;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("tb: failure");
      $finish;
    end
  end

  task automatic load_entry(input logic [3:0] p);
    if (!pt_touched[p]) begin
      pt_touched[p]     = 1'b1;
      pt_rate[p]        = p_init_rate;
      pt_bucket[p]      = p_init_rate;
      pt_next_seq[p]    = '0;
      pt_last_ack[p]    = '0;
      pt_acked[p]       = 1'b0;
      pt_may_dec[p]     = 1'b1;
      pt_first_after[p] = NONE_MARK;
    end
  endtask

  // Computes the result of one item and advances the predicted table.
  task automatic predict_rate_update(input logic mode, input logic [3:0] p,
                                     input logic [31:0] mid, input logic [31:0] aseq);
    rate_result_t r;
    logic [16:0] bsum;
    logic [31:0] prod, inc;
    logic [32:0] nr;
    logic [15:0] cur;
    r = '0;
    if (mode == 1'b0) begin
      if (p == p_leader) begin
        r.rate = pt_touched[p] ? pt_rate[p] : p_init_rate;
      end else begin
        load_entry(p);
        if (pt_bucket[p] >= TOKEN_ONE) begin
          pt_bucket[p] = pt_bucket[p] - TOKEN_ONE;
          r.forwarded = 1'b1;
          r.seq = pt_next_seq[p];
          pt_next_seq[p] = pt_next_seq[p] + 32'd1;
          if (pt_first_after[p] == NONE_MARK) pt_first_after[p] = {1'b0, mid};
        end
        bsum = {1'b0, pt_bucket[p]} + {1'b0, pt_rate[p]};
        pt_bucket[p] = bsum[16] ? 16'hFFFF : bsum[15:0];
        r.rate = pt_rate[p];
      end
    end else begin
      load_entry(p);
      if (pt_acked[p]) begin
        cur = pt_rate[p];
        if (pt_first_after[p] == NONE_MARK || {1'b0, mid} > pt_first_after[p])
          pt_may_dec[p] = 1'b1;
        if ({1'b0, aseq} > {1'b0, pt_last_ack[p]} + 33'd1) begin
          if (pt_may_dec[p]) begin
            prod = ({16'd0, cur} * {24'd0, p_dec_factor}) >> 8;
            if (prod < {16'd0, p_min_rate}) prod = {16'd0, p_min_rate};
            pt_rate[p] = prod[15:0];
            pt_may_dec[p] = 1'b0;
            pt_first_after[p] = NONE_MARK;
            r.kind = KIND_DEC;
          end
        end else begin
          if (cur == 16'd0) inc = 32'hFFFF;
          else inc = ({16'd0, p_inc_step} * {16'd0, p_min_rate}) / {16'd0, cur};
          nr = {17'd0, cur} + {1'b0, inc};
          if (nr > {17'd0, p_max_rate}) nr = {17'd0, p_max_rate};
          pt_rate[p] = nr[15:0];
          r.kind = KIND_INC;
        end
      end
      pt_last_ack[p] = aseq;
      pt_acked[p] = 1'b1;
      r.rate = pt_rate[p];
    end
    expected_results.insert(expected_results.size(), r);
  endtask

  // Sends one transaction after a random gap; valid is held until accepted.
  // Valid stays high after acceptance until the next item or a drain.
  task automatic send_item(input logic mode, input logic [3:0] p,
                           input logic [31:0] mid, input logic [31:0] aseq);
    int gap;
    gap = $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_peer <= p;
    in_message_id <= mid;
    in_ack_sequence <= aseq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_rate_update(mode, p, mid, aseq);
  endtask

  // Result channel: random stalls per result, and a forced hold when asked.
  initial begin : result_checker
    int stall;
    rate_result_t exp_r;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 3);
      if (stall != 0 || receiver_hold) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
        while (receiver_hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.forwarded !== out_forwarded || exp_r.seq !== out_assigned_sequence ||
            exp_r.kind !== out_update_kind || exp_r.rate !== out_peer_rate) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp fwd=%0d seq=%0d kind=%0d rate=%0d, got %0d %0d %0d %0d",
                     exp_r.forwarded, exp_r.seq, exp_r.kind, exp_r.rate, out_forwarded,
                     out_assigned_sequence, out_update_kind, out_peer_rate);
        end
      end
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Register writes happen only while nothing is in flight.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_RATE:  p_min_rate = value;
      REG_MAX_RATE:  p_max_rate = value;
      REG_DEC_FACT:  p_dec_factor = value[7:0];
      REG_INC_STEP:  p_inc_step = value;
      REG_INIT_RATE: p_init_rate = value;
      REG_LEADER:    p_leader = value[3:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] mn, input logic [15:0] mx,
                           input logic [15:0] df, input logic [15:0] st,
                           input logic [15:0] ir, input logic [15:0] ld);
    wait_drained();
    write_reg(REG_MIN_RATE, mn);
    write_reg(REG_MAX_RATE, mx);
    write_reg(REG_DEC_FACT, df);
    write_reg(REG_INC_STEP, st);
    write_reg(REG_INIT_RATE, ir);
    write_reg(REG_LEADER, ld);
  endtask

  function automatic logic [31:0] next_msg();
    msg_counter = msg_counter + 32'd1;
    return msg_counter;
  endfunction

  // Directed: leader sends, first ack, increase, gap decreases, repeated sends,
  // extreme fields, and the top of the ack sequence range.
  task automatic test_directed();
    send_item(1'b0, 4'd0, 32'd1, 32'd0);          // leader, untouched
    send_item(1'b0, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(1'b0, 4'd15, 32'd2, 32'd0);
    send_item(1'b1, 4'd15, 32'd3, 32'd0);         // first ack records only
    send_item(1'b1, 4'd15, 32'd4, 32'd1);         // in order: increase
    send_item(1'b1, 4'd15, 32'd5, 32'd9);         // gap: decrease
    send_item(1'b1, 4'd15, 32'd6, 32'd20);        // gap again: re-armed, decrease
    send_item(1'b1, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF); // re-arms, gap
    send_item(1'b1, 4'd15, 32'hFFFFFFFF, 32'h00000000);
    for (int i = 0; i < 6; i++) send_item(1'b0, 4'd3, next_msg(), 32'd0);
    send_item(1'b1, 4'd0, 32'd0, 32'd0);          // ack to the leader
    send_item(1'b0, 4'd0, 32'd0, 32'd0);          // leader send, touched
  endtask

  // Mostly well-formed per-peer traffic: sends and mostly in-order acks, with some random items.
  task automatic test_random(input int count);
    logic [31:0] ack_seq [NPEERS];
    logic [3:0] p;
    int sel;
    for (int i = 0; i < NPEERS; i++) ack_seq[i] = '0;
    for (int n = 0; n < count; n++) begin
      p = 4'($urandom_range(0, NPEERS - 1));
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_item(1'b0, p, next_msg(), $urandom());
      end else if (sel < 80) begin
        ack_seq[p] = ack_seq[p] + 32'd1;
        send_item(1'b1, p, msg_counter - $urandom_range(0, 8), ack_seq[p]);
      end else if (sel < 93) begin
        ack_seq[p] = ack_seq[p] + $urandom_range(2, 6);
        send_item(1'b1, p, msg_counter - $urandom_range(0, 8), ack_seq[p]);
      end else begin
        send_item(1'($urandom_range(0, 1)), p, $urandom(), $urandom());
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering, then sender pauses.
  task automatic test_backpressure();
    receiver_hold = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk);
        receiver_hold = 1'b0;
      end
      for (int i = 0; i < 8; i++)
        send_item(1'b0, 4'($urandom_range(1, 15)), next_msg(), 32'd0);
    join
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_peer = '0;
    in_message_id = '0;
    in_ack_sequence = '0;
    receiver_hold = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    msg_counter = 32'd100;
    p_min_rate = 16'd64;
    p_max_rate = 16'd1024;
    p_dec_factor = 8'd128;
    p_inc_step = 16'd64;
    p_init_rate = 16'd256;
    p_leader = 4'd0;
    for (int i = 0; i < NPEERS; i++) pt_touched[i] = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(150);
    test_backpressure();
    // Extremes: smallest bounds and a zero factor and step.
    write_all(16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd7);
    test_random(100);
    // Largest values everywhere.
    write_all(16'hFFFF, 16'hFFFF, 16'hFF, 16'hFFFF, 16'hFFFF, 16'd15);
    test_random(100);
    write_all(16'($urandom_range(1, 600)), 16'($urandom_range(600, 65535)),
              16'($urandom_range(0, 255)), 16'($urandom()),
              16'($urandom_range(1, 3000)), 16'($urandom_range(0, 15)));
    test_random(220);
    wait_drained();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
